### design/osdls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osdls_pkg
// Shared types and constants of the OSD video line sequencer.
// ----------------------------------------------------------------------------
package osdls_pkg;

	// Parameter defaults
	localparam int LINE_STRIDE_DEF   = 128;
	localparam int REDRAW_FIELDS_DEF = 2;

	// Geometry
	localparam int NTSC_VISIBLE    = 240;
	localparam int PAL_VISIBLE     = 266;
	localparam int NTSC_TOP        = 16;
	localparam int PAL_TOP         = 28;
	localparam int SPURIOUS_MARGIN = 10;
	localparam int COUNTER_MAX     = 1023;
	localparam int OFFSET_LIMIT    = 20;

	// Field widths
	localparam int CNT_W    = 11;
	localparam int PTR_W    = 16;
	localparam int BYTES_W  = 8;
	localparam int TOTAL_W  = 11;
	localparam int OFF_W    = 6;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 11;

	// Stream widths
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 2;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_NTSC = 2'd1,
		MODE_PAL  = 2'd2
	} video_mode_t;

	typedef enum logic {
		EV_HSYNC = 1'b0,
		EV_VSYNC = 1'b1
	} sync_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VERTICAL_OFFSET    = 8'd0,
		REG_PAL_LINE_THRESHOLD = 8'd1,
		REG_NTSC_LINE_BYTES    = 8'd2,
		REG_PAL_LINE_BYTES     = 8'd3
	} cfg_reg_t;

	// Clamp a raw 6-bit signed offset to +/- OFFSET_LIMIT
	function automatic logic signed [OFF_W-1:0] clamp_offset(input logic [OFF_W-1:0] raw);
		logic signed [OFF_W-1:0] v;
		v = $signed(raw);
		if (v > OFF_W'(OFFSET_LIMIT))
			return OFF_W'(OFFSET_LIMIT);
		else if (v < -OFF_W'(OFFSET_LIMIT))
			return -OFF_W'(OFFSET_LIMIT);
		else
			return v;
	endfunction

endpackage : osdls_pkg
`default_nettype wire

### design/osd_video_line_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osd_video_line_sequencer
// Line and field sequencer for an on-screen-display overlay.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries sync events (tuser: hsync or vsync, tdata: output busy flag).
//   Every event gives exactly one result transfer on m_*: line transfer
//   request for an hsync, field summary for a vsync, plus current bank, video
//   mode and last line total.
//   cfg_* writes the four registers; only write while no event is in flight.
//   Each event is held in the input register, then passes through the
//   sequencing logic into the result register that drives m_*. One event
//   per cycle is sustained while the receiver does not stall; the line
//   counter and pointer update in the same cycle as the result is registered.
//   When the receiver stalls, the result register holds and one more event
//   waits in the input register; s_tready then drops.
//   Reset (arst_n low) clears all state: counter and pointer zero, mode none,
//   bank one, PAL pending for the first field, registers to their defaults.
// ----------------------------------------------------------------------------
module osd_video_line_sequencer #(
	parameter int LINE_STRIDE   = osdls_pkg::LINE_STRIDE_DEF,
	parameter int REDRAW_FIELDS = osdls_pkg::REDRAW_FIELDS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// event stream
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [osdls_pkg::S_TDATA_W-1:0]    s_tdata,  // [0] output_busy, [7:1] zero
	input  wire logic                               s_tuser,  // [0] func
	// result stream
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [osdls_pkg::M_TDATA_W-1:0]         m_tdata,  // [15:0] line_offset,
	                                                          // [23:16] transfer_bytes,
	                                                          // [24] redraw, [25] display_bank,
	                                                          // [27:26] video_mode,
	                                                          // [38:28] line_total, [39] zero
	output logic [osdls_pkg::M_TUSER_W-1:0]         m_tuser,  // [0] line_issued,
	                                                          // [1] field_accepted
	// register writes
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [osdls_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [osdls_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import osdls_pkg::*;

	localparam int PHASE_W = (REDRAW_FIELDS > 1) ? $clog2(REDRAW_FIELDS) : 1;

	// Registers
	logic signed [OFF_W-1:0] voff_q;
	logic [TOTAL_W-1:0]      pal_thr_q;
	logic [BYTES_W-1:0]      ntsc_len_q;
	logic [BYTES_W-1:0]      pal_len_q;

	// Sequencer state
	logic signed [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0]        ptr_q;
	video_mode_t             mode_q;
	logic                    pend_pal_q;
	logic [PHASE_W-1:0]      phase_q;
	logic                    bank_q;
	logic [TOTAL_W-1:0]      total_q;

	// Input register
	logic       valid_s1;
	sync_kind_t kind_s1;
	logic       busy_s1;

	// Result register
	logic               out_valid_q;
	logic               issued_q;
	logic [PTR_W-1:0]   offs_q;
	logic [BYTES_W-1:0] bytes_q;
	logic               acc_q;
	logic               redraw_q;

	logic advance;

	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// ------------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voff_q     <= '0;
			pal_thr_q  <= TOTAL_W'(300);
			ntsc_len_q <= BYTES_W'(88);
			pal_len_q  <= BYTES_W'(92);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_VERTICAL_OFFSET:    voff_q     <= clamp_offset(cfg_data[OFF_W-1:0]);
				REG_PAL_LINE_THRESHOLD: pal_thr_q  <= cfg_data[TOTAL_W-1:0];
				REG_NTSC_LINE_BYTES:    ntsc_len_q <= cfg_data[BYTES_W-1:0];
				REG_PAL_LINE_BYTES:     pal_len_q  <= cfg_data[BYTES_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Input register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= sync_kind_t'(s_tuser);
			busy_s1 <= s_tdata[0];
		end
	end

	// ------------------------------------------------------------------------
	// Sequencing logic
	// ------------------------------------------------------------------------
	logic                    is_ntsc;
	logic signed [CNT_W-1:0] cnt_inc;
	logic [CNT_W-2:0]        visible;
	logic                    in_band;
	logic                    vs_ok;
	logic signed [CNT_W:0]   total_c;
	logic                    to_pal;
	video_mode_t             mode_nxt;
	logic [CNT_W-1:0]        top_nxt;
	logic signed [CNT_W-1:0] cnt_restart;
	logic [PHASE_W:0]        phase_inc;
	logic                    redraw_c;

	always_comb begin
		is_ntsc = (mode_q == MODE_NTSC);
		cnt_inc = (cnt_q != CNT_W'(COUNTER_MAX)) ? cnt_q + CNT_W'(1) : cnt_q;
		visible = is_ntsc ? (CNT_W-1)'(NTSC_VISIBLE) : (CNT_W-1)'(PAL_VISIBLE);
		in_band = !cnt_inc[CNT_W-1] && (cnt_inc[CNT_W-2:0] < visible) && !busy_s1;

		// spurious vsync: fewer lines than the NTSC band less a margin
		vs_ok = !cnt_q[CNT_W-1] &&
			(cnt_q[CNT_W-2:0] >= (CNT_W-1)'(NTSC_VISIBLE - SPURIOUS_MARGIN));

		total_c = $signed({2'b00, cnt_q[CNT_W-2:0]})
			+ (is_ntsc ? (CNT_W+1)'(NTSC_TOP) : (CNT_W+1)'(PAL_TOP))
			+ (CNT_W+1)'(voff_q);
		to_pal   = pend_pal_q || ($unsigned(total_c) > {1'b0, pal_thr_q});
		mode_nxt = to_pal ? MODE_PAL : MODE_NTSC;
		top_nxt  = to_pal ? CNT_W'(PAL_TOP) : CNT_W'(NTSC_TOP);
		cnt_restart = -($signed(top_nxt) + CNT_W'(voff_q));

		phase_inc = {1'b0, phase_q} + (PHASE_W+1)'(1);
		redraw_c  = (kind_s1 == EV_VSYNC) && vs_ok &&
			(phase_inc >= (PHASE_W+1)'(REDRAW_FIELDS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			ptr_q      <= '0;
			mode_q     <= MODE_NONE;
			pend_pal_q <= 1'b1;
			phase_q    <= '0;
			bank_q     <= 1'b1;
			total_q    <= '0;
		end else if (advance) begin
			if (kind_s1 == EV_HSYNC) begin
				cnt_q <= cnt_inc;
				if (in_band)
					ptr_q <= ptr_q + PTR_W'(LINE_STRIDE);
			end else if (vs_ok) begin
				total_q    <= total_c[TOTAL_W-1:0];
				mode_q     <= mode_nxt;
				pend_pal_q <= 1'b0;
				cnt_q      <= cnt_restart;
				ptr_q      <= '0;
				if (redraw_c) begin
					phase_q <= '0;
					bank_q  <= ~bank_q;
				end else begin
					phase_q <= phase_inc[PHASE_W-1:0];
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			issued_q <= (kind_s1 == EV_HSYNC) && in_band;
			offs_q   <= ((kind_s1 == EV_HSYNC) && in_band) ? ptr_q : '0;
			bytes_q  <= ((kind_s1 == EV_HSYNC) && in_band) ?
				(is_ntsc ? ntsc_len_q : pal_len_q) : '0;
			acc_q    <= (kind_s1 == EV_VSYNC) && vs_ok;
			redraw_q <= redraw_c;
		end
	end

	// bank, mode and total are shown as they stand after the event
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, total_q, mode_q, bank_q, redraw_q, bytes_q, offs_q};
	assign m_tuser  = {acc_q, issued_q};

`ifndef SYNTHESIS
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("line issue and field accept in one result");

	a_redraw_field: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[24]) |-> m_tuser[1])
		else $error("redraw without accepted field");

	a_bank_swap: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && redraw_c) |=> $stable(bank_q))
		else $error("display bank changed without redraw");

	a_cnt_floor: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= -CNT_W'(PAL_TOP + OFFSET_LIMIT))
		else $error("line counter below top margin limit");
`endif

endmodule : osd_video_line_sequencer
`default_nettype wire
